@@ src/rhsl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rhsl_pkg;

    localparam int CHAN_W   = 8;
    localparam int QUOT_W   = 15;
    localparam int DEN_W    = 9;
    localparam int NUM_W    = QUOT_W + DEN_W;

    localparam int H60      = 3840;
    localparam int PCT_FULL = 25600;
    localparam int LIGHT_DEN = 510;

    typedef struct packed {
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;
        logic [QUOT_W-1:0] low;
    } t_lane;

endpackage

`default_nettype wire

@@ src/rhsl_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhsl_prep (
    input  wire logic                        i_clk,
    input  wire logic [1:0]                  i_en,
    input  wire logic [rhsl_pkg::CHAN_W-1:0] i_red,
    input  wire logic [rhsl_pkg::CHAN_W-1:0] i_green,
    input  wire logic [rhsl_pkg::CHAN_W-1:0] i_blue,
    output rhsl_pkg::t_lane                  o_hue_lane,
    output rhsl_pkg::t_lane                  o_sat_lane,
    output rhsl_pkg::t_lane                  o_light_lane
);
    import rhsl_pkg::*;

    logic [CHAN_W-1:0]     mx;
    logic [CHAN_W-1:0]     mn;
    logic signed [8:0]     n_diff;
    logic [14:0]           n_base;

    logic [CHAN_W-1:0]     r_delta;
    logic [8:0]            r_sum;
    logic signed [8:0]     r_diff;
    logic [14:0]           r_base;

    logic [22:0]           prod_b;
    logic signed [21:0]    prod_d;
    logic signed [24:0]    hnum;
    logic [NUM_W-1:0]      hue_num;
    logic [NUM_W-1:0]      sat_num;
    logic [NUM_W-1:0]      light_num;
    logic [DEN_W-1:0]      sat_den;
    logic                  grey;

    t_lane                 n_hue;
    t_lane                 n_sat;
    t_lane                 n_light;
    t_lane                 r_hue;
    t_lane                 r_sat;
    t_lane                 r_light;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        if (i_red == mx) begin
            n_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
            n_base = n_diff[8] ? 15'(6 * H60) : 15'd0;
        end else if (i_green == mx) begin
            n_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
            n_base = 15'(2 * H60);
        end else begin
            n_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
            n_base = 15'(4 * H60);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_delta <= mx - mn;
            r_sum   <= {1'b0, mx} + {1'b0, mn};
            r_diff  <= n_diff;
            r_base  <= n_base;
        end
    end

    always_comb begin
        grey    = (r_delta == '0);
        prod_b  = {8'd0, r_base} * {15'd0, r_delta};
        prod_d  = 22'(r_diff) * 22'sd3840;
        hnum    = $signed({2'b00, prod_b}) + 25'(prod_d);
        hue_num = (hnum < 0) ? '0 : hnum[NUM_W-1:0];
        sat_num = NUM_W'(PCT_FULL) * NUM_W'(r_delta);
        light_num = NUM_W'(PCT_FULL) * NUM_W'(r_sum);
        sat_den = (r_sum >= 9'd255) ? (9'(LIGHT_DEN) - r_sum) : r_sum;

        if (grey) begin
            n_hue = '{den: DEN_W'(1), rem: '0, low: '0};
            n_sat = '{den: DEN_W'(1), rem: '0, low: '0};
        end else begin
            n_hue = '{den: {1'b0, r_delta}, rem: hue_num[NUM_W-1:QUOT_W],
                      low: hue_num[QUOT_W-1:0]};
            n_sat = '{den: sat_den, rem: sat_num[NUM_W-1:QUOT_W],
                      low: sat_num[QUOT_W-1:0]};
        end
        n_light = '{den: DEN_W'(LIGHT_DEN), rem: light_num[NUM_W-1:QUOT_W],
                    low: light_num[QUOT_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_light <= n_light;
        end
    end

    assign o_hue_lane   = r_hue;
    assign o_sat_lane   = r_sat;
    assign o_light_lane = r_light;

endmodule

`default_nettype wire

@@ src/rhsl_div_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhsl_div_step (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire rhsl_pkg::t_lane i_lane,
    output rhsl_pkg::t_lane o_lane
);
    import rhsl_pkg::*;

    logic [DEN_W:0] trial;
    logic           ge;
    t_lane          n_lane;
    t_lane          r_lane;

    always_comb begin
        trial      = {i_lane.rem, i_lane.low[QUOT_W-1]};
        ge         = (trial >= {1'b0, i_lane.den});
        n_lane.den = i_lane.den;
        n_lane.rem = ge ? DEN_W'(trial - {1'b0, i_lane.den}) : trial[DEN_W-1:0];
        n_lane.low = {i_lane.low[QUOT_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

@@ src/rgb_to_hsl.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake          Payload
// input    in         i_valid / o_stall  i_red, i_green, i_blue (8 bits each)
// output   out        o_valid / i_stall  o_hue, o_saturation, o_lightness (15 bits each)
//
// One pixel per cycle while o_stall is low; the pipeline has two prep stages, then 15 divider stages,
// one quotient bit per stage in each of the hue, saturation and lightness lanes.
// Reset clears the valid bits of all stages; payload registers are not reset.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// collapse and o_stall rises only when every stage holds a beat and i_stall is high.

module rgb_to_hsl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [rhsl_pkg::CHAN_W-1:0]  i_red,
    input  wire logic [rhsl_pkg::CHAN_W-1:0]  i_green,
    input  wire logic [rhsl_pkg::CHAN_W-1:0]  i_blue,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [rhsl_pkg::QUOT_W-1:0]       o_hue,
    output logic [rhsl_pkg::QUOT_W-1:0]       o_saturation,
    output logic [rhsl_pkg::QUOT_W-1:0]       o_lightness
);
    import rhsl_pkg::*;

    localparam int NSTG = QUOT_W + 2;

    logic [NSTG-1:0] r_valid;
    logic [NSTG-1:0] en;

    t_lane hue_lane   [QUOT_W+1];
    t_lane sat_lane   [QUOT_W+1];
    t_lane light_lane [QUOT_W+1];

    always_comb begin
        en[NSTG-1] = !r_valid[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) r_valid[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_valid[k] <= r_valid[k-1];
            end
        end
    end

    rhsl_prep u_prep (
        .i_clk        (i_clk),
        .i_en         (en[1:0]),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_hue_lane   (hue_lane[0]),
        .o_sat_lane   (sat_lane[0]),
        .o_light_lane (light_lane[0])
    );

    for (genvar s = 0; s < QUOT_W; s++) begin : g_div
        rhsl_div_step u_hue (
            .i_clk  (i_clk),
            .i_en   (en[s+2]),
            .i_lane (hue_lane[s]),
            .o_lane (hue_lane[s+1])
        );
        rhsl_div_step u_sat (
            .i_clk  (i_clk),
            .i_en   (en[s+2]),
            .i_lane (sat_lane[s]),
            .o_lane (sat_lane[s+1])
        );
        rhsl_div_step u_light (
            .i_clk  (i_clk),
            .i_en   (en[s+2]),
            .i_lane (light_lane[s]),
            .o_lane (light_lane[s+1])
        );
    end

    assign o_stall      = !en[0];
    assign o_valid      = r_valid[NSTG-1];
    assign o_hue        = hue_lane[QUOT_W].low;
    assign o_saturation = sat_lane[QUOT_W].low;
    assign o_lightness  = light_lane[QUOT_W].low;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_valid) && i_stall)
        else $error("input stalled while a stage is free");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hue) && $stable(o_lightness))
        else $error("held output beat changed");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hue < 15'd23040)
        else $error("hue out of range");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_saturation <= 15'(PCT_FULL)) && (o_lightness <= 15'(PCT_FULL)))
        else $error("saturation or lightness out of range");

endmodule

`default_nettype wire
